// ----- rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// When the trigger holds, the consequence holds at the next clock edge.
`define ASSERT_NEXT(label, trig, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cons)) else $error(msg);

`endif

// ----- rtl/hpsp_pkg.sv -----
// ----------------------------------------------------------------------------
// hpsp_pkg
// Types, codes and helper functions of the handshake packet stream parser.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package hpsp_pkg;

  typedef enum logic [4:0] {
    PH_MAGIC0      = 5'd0,
    PH_MAGIC1      = 5'd1,
    PH_MAGIC2      = 5'd2,
    PH_MAGIC3      = 5'd3,
    PH_VERSION     = 5'd4,
    PH_KIND        = 5'd5,
    PH_PAD         = 5'd6,
    PH_PROTOCOL    = 5'd7,
    PH_ENG_MAJOR   = 5'd8,
    PH_ENG_MINOR   = 5'd9,
    PH_ENG_PATCH   = 5'd10,
    PH_SUPPORTED   = 5'd11,
    PH_REQUIRED    = 5'd12,
    PH_NONCE       = 5'd13,
    PH_BUILD_LEN   = 5'd14,
    PH_BUILD_DATA  = 5'd15,
    PH_REASON_LEN  = 5'd16,
    PH_REASON_DATA = 5'd17,
    PH_DONE        = 5'd18,
    PH_DISCARD     = 5'd19
  } phase_t;

  typedef enum logic [2:0] {
    REG_WIRE_VERSION  = 3'd0,
    REG_MAX_PACKET    = 3'd1,
    REG_MAX_BUILD_ID  = 3'd2,
    REG_MAX_REASON    = 3'd3,
    REG_CODE_HELLO    = 3'd4,
    REG_CODE_ACCEPT   = 3'd5,
    REG_CODE_REJECT   = 3'd6
  } reg_idx_t;

  localparam logic [3:0] ST_OK           = 4'd0;
  localparam logic [3:0] ST_TOO_LONG     = 4'd1;
  localparam logic [3:0] ST_MAGIC        = 4'd2;
  localparam logic [3:0] ST_VERSION      = 4'd3;
  localparam logic [3:0] ST_KIND         = 4'd4;
  localparam logic [3:0] ST_STRING_LIMIT = 4'd5;
  localparam logic [3:0] ST_TRUNCATED    = 4'd6;
  localparam logic [3:0] ST_TRAILING     = 4'd7;
  localparam logic [3:0] ST_ZERO_NONCE   = 4'd8;
  localparam logic [3:0] ST_EMPTY_BUILD  = 4'd9;
  localparam logic [3:0] ST_STRAY_REASON = 4'd10;

  localparam logic [3:0] TAG_KIND    = 4'd0;
  localparam logic [3:0] TAG_BUILD   = 4'd8;
  localparam logic [3:0] TAG_REASON  = 4'd9;
  localparam logic [3:0] TAG_VERDICT = 4'd10;

  localparam logic [15:0] RST_WIRE_VERSION = 16'd1;
  localparam logic [15:0] RST_MAX_PACKET   = 16'd1024;
  localparam logic [15:0] RST_MAX_BUILD_ID = 16'd64;
  localparam logic [15:0] RST_MAX_REASON   = 16'd256;
  localparam logic [7:0]  RST_CODE_HELLO   = 8'd0;
  localparam logic [7:0]  RST_CODE_ACCEPT  = 8'd1;
  localparam logic [7:0]  RST_CODE_REJECT  = 8'd2;

  localparam logic [16:0] COUNT_MAX = 17'h1FFFF;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  typedef struct packed {
    logic [3:0]  tag;
    logic [63:0] value;
    logic [3:0]  status;
    logic        done;
  } result_t;

  function automatic logic [7:0] sync_byte(input logic [1:0] idx);
    logic [7:0] b;
    unique case (idx)
      2'd0: b = 8'h4E;
      2'd1: b = 8'h43;
      2'd2: b = 8'h48;
      2'd3: b = 8'h53;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  function automatic logic [3:0] bytes_of_phase(input phase_t ph);
    logic [3:0] n;
    if (ph == PH_VERSION || ph == PH_BUILD_LEN || ph == PH_REASON_LEN) begin
      n = 4'd2;
    end else if (ph >= PH_PROTOCOL && ph <= PH_ENG_PATCH) begin
      n = 4'd2;
    end else if (ph >= PH_SUPPORTED && ph <= PH_NONCE) begin
      n = 4'd8;
    end else begin
      n = 4'd1;
    end
    return n;
  endfunction

endpackage

// ----- rtl/handshake_packet_stream_parser_top.sv -----
// ----------------------------------------------------------------------------
// handshake_packet_stream_parser_top
// Byte-serial parser for handshake packets with field and verdict requests.
// ----------------------------------------------------------------------------
//
//   Channel   Handshake             Payload
//   input     in_valid / in_stall   data_byte, end_of_packet
//   output    out_valid / out_stall field_tag, field_value, status, packet_done
//   config    APB write, pready=1   seven registers at byte address 4*i
//
// One byte is accepted per cycle while in_stall is low; the parse step and
// the byte counter settle between the state registers and a four-entry
// result queue. A byte yields up to two requests, so input stalls when fewer
// than two queue slots are free; the queue drains one request per cycle while
// out_stall is low. An accepted byte's requests are registered in the queue.
// Synchronous reset returns the parser to the first magic byte and empties
// the queue; configuration registers return to their reset values.
//
`timescale 1ns / 1ps
`include "assert_macros.svh"

module handshake_packet_stream_parser_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        end_of_packet,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  field_tag,
  output logic [63:0] field_value,
  output logic [3:0]  status,
  output logic        packet_done,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  import hpsp_pkg::*;

  logic [15:0] cfg_wire_ver;
  logic [15:0] cfg_pkt_limit;
  logic [15:0] cfg_build_limit;
  logic [15:0] cfg_reason_limit;
  logic [7:0]  code_client_hello;
  logic [7:0]  code_server_accept;
  logic [7:0]  code_server_reject;

  phase_t      phase, phase_next;
  logic [2:0]  byte_in_field, byte_in_field_next;
  logic [63:0] field_acc, field_acc_next;
  logic [15:0] string_remaining, string_remaining_next;
  logic [16:0] byte_count, byte_count_next;
  logic [3:0]  first_error, first_error_next;
  logic        kind_is_reject, kind_is_reject_next;
  logic        nonce_is_zero, nonce_is_zero_next;
  logic        build_id_empty, build_id_empty_next;
  logic        reason_present, reason_present_next;

  result_t               fifo_mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0]    wr_ptr, rd_ptr;
  logic [FIFO_AW:0]      fifo_count, fifo_count_next;

  logic        cfg_write;
  logic        in_accept, out_accept;
  logic        over;
  logic        is_field_phase, is_string_phase, field_complete, kind_ok;
  logic [63:0] acc_shift;
  logic        has_field, push_field, push_verdict;
  logic [3:0]  res_tag;
  logic [63:0] res_value;
  logic [3:0]  verdict;
  result_t     field_res, verdict_res, push0, push1;
  logic [1:0]  push_count;

  // Configuration port.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_wire_ver       <= RST_WIRE_VERSION;
      cfg_pkt_limit      <= RST_MAX_PACKET;
      cfg_build_limit    <= RST_MAX_BUILD_ID;
      cfg_reason_limit   <= RST_MAX_REASON;
      code_client_hello  <= RST_CODE_HELLO;
      code_server_accept <= RST_CODE_ACCEPT;
      code_server_reject <= RST_CODE_REJECT;
    end else if (cfg_write) begin
      unique case (paddr[4:2])
        REG_WIRE_VERSION: cfg_wire_ver       <= pwdata[15:0];
        REG_MAX_PACKET:   cfg_pkt_limit      <= pwdata[15:0];
        REG_MAX_BUILD_ID: cfg_build_limit    <= pwdata[15:0];
        REG_MAX_REASON:   cfg_reason_limit   <= pwdata[15:0];
        REG_CODE_HELLO:   code_client_hello  <= pwdata[7:0];
        REG_CODE_ACCEPT:  code_server_accept <= pwdata[7:0];
        REG_CODE_REJECT:  code_server_reject <= pwdata[7:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      REG_WIRE_VERSION: prdata = {16'd0, cfg_wire_ver};
      REG_MAX_PACKET:   prdata = {16'd0, cfg_pkt_limit};
      REG_MAX_BUILD_ID: prdata = {16'd0, cfg_build_limit};
      REG_MAX_REASON:   prdata = {16'd0, cfg_reason_limit};
      REG_CODE_HELLO:   prdata = {24'd0, code_client_hello};
      REG_CODE_ACCEPT:  prdata = {24'd0, code_server_accept};
      REG_CODE_REJECT:  prdata = {24'd0, code_server_reject};
      default:          prdata = 32'd0;
    endcase
  end

  // Handshakes. Two free slots are kept so a byte can always push both requests.
  assign in_stall   = fifo_count > (FIFO_AW + 1)'(FIFO_DEPTH - 2);
  assign out_valid  = fifo_count != '0;
  assign in_accept  = in_valid && !in_stall;
  assign out_accept = out_valid && !out_stall;

  // Shared decode of the current byte.
  assign byte_count_next = (byte_count == COUNT_MAX) ? byte_count : byte_count + 17'd1;
  assign over            = byte_count_next > {1'b0, cfg_pkt_limit};
  assign is_string_phase = (phase == PH_BUILD_DATA) || (phase == PH_REASON_DATA);
  assign is_field_phase  = (phase >= PH_VERSION) && (phase < PH_DONE) && !is_string_phase;
  assign acc_shift       = field_acc | ({56'd0, data_byte} << {byte_in_field, 3'b000});
  assign field_complete  = ({1'b0, byte_in_field} + 4'd1) >= bytes_of_phase(phase);
  assign kind_ok         = (acc_shift == {56'd0, code_client_hello}) ||
                           (acc_shift == {56'd0, code_server_accept}) ||
                           (acc_shift == {56'd0, code_server_reject});

  // Next parse state.
  always_comb begin
    phase_next            = phase;
    byte_in_field_next    = byte_in_field;
    field_acc_next        = field_acc;
    string_remaining_next = string_remaining;
    first_error_next      = first_error;
    kind_is_reject_next   = kind_is_reject;
    nonce_is_zero_next    = nonce_is_zero;
    build_id_empty_next   = build_id_empty;
    reason_present_next   = reason_present;
    if (phase < PH_VERSION) begin
      if (data_byte != sync_byte(phase[1:0]) && first_error == ST_OK) begin
        first_error_next = ST_MAGIC;
      end
      if (phase == PH_MAGIC3 && (first_error != ST_OK || data_byte != sync_byte(2'd3))) begin
        phase_next = PH_DISCARD;
      end else begin
        phase_next = phase_t'(5'(phase + 5'd1));
      end
    end else if (is_field_phase) begin
      field_acc_next     = acc_shift;
      byte_in_field_next = byte_in_field + 3'd1;
      if (field_complete) begin
        byte_in_field_next = 3'd0;
        field_acc_next     = 64'd0;
        priority if (phase == PH_VERSION) begin
          if (acc_shift != {48'd0, cfg_wire_ver}) begin
            first_error_next = ST_VERSION;
            phase_next       = PH_DISCARD;
          end else begin
            phase_next = PH_KIND;
          end
        end else if (phase == PH_KIND) begin
          if (!kind_ok) begin
            first_error_next = ST_KIND;
            phase_next       = PH_DISCARD;
          end else begin
            kind_is_reject_next = acc_shift == {56'd0, code_server_reject};
            phase_next          = PH_PAD;
          end
        end else if (phase == PH_PAD) begin
          phase_next = PH_PROTOCOL;
        end else if (phase < PH_BUILD_LEN) begin
          if (phase == PH_NONCE) begin
            nonce_is_zero_next = acc_shift == 64'd0;
          end
          phase_next = phase_t'(5'(phase + 5'd1));
        end else if (phase == PH_BUILD_LEN) begin
          if (acc_shift > {48'd0, cfg_build_limit}) begin
            first_error_next = ST_STRING_LIMIT;
            phase_next       = PH_DISCARD;
          end else begin
            build_id_empty_next   = acc_shift == 64'd0;
            string_remaining_next = acc_shift[15:0];
            phase_next            = (acc_shift != 64'd0) ? PH_BUILD_DATA : PH_REASON_LEN;
          end
        end else begin
          if (acc_shift > {48'd0, cfg_reason_limit}) begin
            first_error_next = ST_STRING_LIMIT;
            phase_next       = PH_DISCARD;
          end else begin
            reason_present_next   = acc_shift != 64'd0;
            string_remaining_next = acc_shift[15:0];
            phase_next            = (acc_shift != 64'd0) ? PH_REASON_DATA : PH_DONE;
          end
        end
      end
    end else if (is_string_phase) begin
      if (string_remaining != 16'd0) begin
        string_remaining_next = string_remaining - 16'd1;
      end
      if (string_remaining <= 16'd1) begin
        phase_next = (phase == PH_BUILD_DATA) ? PH_REASON_LEN : PH_DONE;
      end
    end else if (phase == PH_DONE) begin
      first_error_next = ST_TRAILING;
      phase_next       = PH_DISCARD;
    end
  end

  // Requests produced by the current byte.
  always_comb begin
    has_field = 1'b0;
    res_tag   = TAG_KIND;
    res_value = acc_shift;
    if (is_field_phase && field_complete) begin
      if (phase == PH_KIND) begin
        has_field = kind_ok;
        res_tag   = TAG_KIND;
      end else if (phase >= PH_PROTOCOL && phase <= PH_NONCE) begin
        has_field = 1'b1;
        res_tag   = 4'(5'(phase) - 5'd6);
      end
    end else if (is_string_phase) begin
      has_field = 1'b1;
      res_tag   = (phase == PH_BUILD_DATA) ? TAG_BUILD : TAG_REASON;
      res_value = {56'd0, data_byte};
    end
  end

  always_comb begin
    priority if (over) begin
      verdict = ST_TOO_LONG;
    end else if (phase_next < PH_VERSION) begin
      verdict = ST_TRUNCATED;
    end else if (first_error_next != ST_OK) begin
      verdict = first_error_next;
    end else if (phase_next != PH_DONE) begin
      verdict = ST_TRUNCATED;
    end else if (nonce_is_zero_next) begin
      verdict = ST_ZERO_NONCE;
    end else if (build_id_empty_next) begin
      verdict = ST_EMPTY_BUILD;
    end else if (!kind_is_reject_next && reason_present_next) begin
      verdict = ST_STRAY_REASON;
    end else begin
      verdict = ST_OK;
    end
  end

  assign push_field   = has_field && !over;
  assign push_verdict = end_of_packet;
  assign field_res    = '{tag: res_tag, value: res_value, status: ST_OK, done: 1'b0};
  assign verdict_res  = '{tag: TAG_VERDICT, value: 64'd0, status: verdict, done: 1'b1};
  assign push0        = push_field ? field_res : verdict_res;
  assign push1        = verdict_res;
  assign push_count   = {1'b0, push_field} + {1'b0, push_verdict};

  // Parser state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_MAGIC0;
      byte_in_field    <= 3'd0;
      field_acc        <= 64'd0;
      string_remaining <= 16'd0;
      byte_count       <= 17'd0;
      first_error      <= ST_OK;
      kind_is_reject   <= 1'b0;
      nonce_is_zero    <= 1'b1;
      build_id_empty   <= 1'b1;
      reason_present   <= 1'b0;
    end else if (in_accept) begin
      if (end_of_packet) begin
        phase            <= PH_MAGIC0;
        byte_in_field    <= 3'd0;
        field_acc        <= 64'd0;
        string_remaining <= 16'd0;
        byte_count       <= 17'd0;
        first_error      <= ST_OK;
        kind_is_reject   <= 1'b0;
        nonce_is_zero    <= 1'b1;
        build_id_empty   <= 1'b1;
        reason_present   <= 1'b0;
      end else begin
        phase            <= phase_next;
        byte_in_field    <= byte_in_field_next;
        field_acc        <= field_acc_next;
        string_remaining <= string_remaining_next;
        byte_count       <= byte_count_next;
        first_error      <= first_error_next;
        kind_is_reject   <= kind_is_reject_next;
        nonce_is_zero    <= nonce_is_zero_next;
        build_id_empty   <= build_id_empty_next;
        reason_present   <= reason_present_next;
      end
    end
  end

  // Result queue.
  always_comb begin
    fifo_count_next = fifo_count;
    if (in_accept) begin
      fifo_count_next = fifo_count_next + {{(FIFO_AW - 1){1'b0}}, push_count};
    end
    if (out_accept) begin
      fifo_count_next = fifo_count_next - (FIFO_AW + 1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr     <= '0;
      rd_ptr     <= '0;
      fifo_count <= '0;
    end else begin
      fifo_count <= fifo_count_next;
      if (in_accept) begin
        wr_ptr <= wr_ptr + FIFO_AW'(push_count);
      end
      if (out_accept) begin
        rd_ptr <= rd_ptr + FIFO_AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      if (push_field || push_verdict) begin
        fifo_mem[wr_ptr] <= push0;
      end
      if (push_field && push_verdict) begin
        fifo_mem[wr_ptr + FIFO_AW'(1)] <= push1;
      end
    end
  end

  assign field_tag   = fifo_mem[rd_ptr].tag;
  assign field_value = fifo_mem[rd_ptr].value;
  assign status      = fifo_mem[rd_ptr].status;
  assign packet_done = fifo_mem[rd_ptr].done;

  // Assertions.
  `ASSERT_ALWAYS(a_fifo_bound, fifo_count <= (FIFO_AW + 1)'(FIFO_DEPTH), "result queue overflow")
  `ASSERT_NEXT(a_eop_clears, in_accept && end_of_packet, phase == PH_MAGIC0 && byte_count == 17'd0 && first_error == ST_OK, "packet state not cleared after last byte")
  `ASSERT_ALWAYS(a_error_discard, first_error == ST_OK || phase == PH_DISCARD || phase < PH_VERSION, "error recorded while still parsing fields")
  `ASSERT_ALWAYS(a_string_len, !(phase == PH_BUILD_DATA || phase == PH_REASON_DATA) || string_remaining != 16'd0, "string phase with no bytes left")

endmodule
